// File: sv/pwfd_pkg.sv
// Shared constants and helpers for the pulse width frame decoder.
package pwfd_pkg;

    localparam int UNIT_SLOTS_DEFAULT = 48;

    // Interval rounding: units = floor((interval + 510) / 1021).
    localparam int UNIT_US      = 1021;
    localparam int UNIT_HALF    = UNIT_US / 2;
    localparam int RECIP_SHIFT  = 26;
    localparam int UNIT_RECIP   = ((1 << RECIP_SHIFT) + UNIT_US - 1) / UNIT_US;
    localparam int ROUND_W      = 17;
    localparam int PROD_W       = 34;
    localparam int UNIT_W       = 8;

    localparam logic [15:0] GAP_RESET = 16'd10000;

    // Frame layout.
    localparam int MIN_FRAME_UNITS = 35;
    localparam int PAIR_FIRST      = 5;
    localparam int WORD_BITS       = 15;
    localparam int DEC_LAST        = PAIR_FIRST + 2 * WORD_BITS - 1;
    localparam logic [UNIT_W-1:0] HDR1_LO = 8'd3;
    localparam logic [UNIT_W-1:0] HDR1_HI = 8'd5;
    localparam logic [UNIT_W-1:0] HDR_LO  = 8'd2;
    localparam logic [UNIT_W-1:0] HDR_HI  = 8'd4;
    localparam logic [UNIT_W-1:0] SYM_ONE = 8'd1;
    localparam logic [UNIT_W-1:0] SYM_TWO = 8'd2;

    localparam logic [15:0] STATUS_VALID = 16'h8000;
    localparam logic [14:0] SLOT0_MASK   = 15'h0070;
    localparam logic [14:0] SLOT1_MASK   = 15'h0380;
    localparam logic [14:0] SLOT2_MASK   = 15'h1C00;
    localparam logic [14:0] SLOT3_MASK   = 15'h6000;

    // Presence scoring.
    localparam logic [3:0] SCORE_MAX  = 4'd10;
    localparam logic [3:0] SCORE_UP   = 4'd2;
    localparam logic [3:0] STABLE_ON  = 4'd4;

    function automatic logic [3:0] presence_of(input logic [14:0] word);
        presence_of = {|(word & SLOT3_MASK), |(word & SLOT2_MASK),
                       |(word & SLOT1_MASK), |(word & SLOT0_MASK)};
    endfunction

endpackage

// File: sv/pulse_width_frame_decoder_core.sv
// Top level of the pulse width frame decoder: unit store, frame decode and presence scoring.
//
// Each accepted word is the microsecond timestamp of one edge on the signal
// line. The block forms the 16-bit wrapped interval to the previous edge and
// rounds it to units of 1021 us, then appends the unit to a unit store of
// UNIT_SLOTS entries held in a synchronous memory with one write port and one
// read port (units beyond the store's depth are dropped until the next gap). An
// interval above the threshold register closes a frame: if at least 35 units
// are stored, the sequencer sweeps entries 1 through 34 out of the memory, one
// read a cycle, checking the header units and decoding fifteen (1,2)/(2,1) unit
// pairs into a word. A good frame updates four presence scores and produces one
// result word on the output channel, which is held in an output register until
// it is taken. An ordinary edge occupies the block through acceptance, the
// reciprocal multiply and the store write, and in_ready returns after the store
// write. An edge that closes a frame of enough units occupies it through
// acceptance, the multiply, the memory sweep with its registered checks,
// scoring and the write of the gap unit. A rejected frame skips scoring.
// Scoring also waits for as long as the previous result is still held at the
// output. A new edge is accepted while a result still waits at the output. The
// threshold register is written through cfg_we and cfg_wdata and is sampled
// when each edge is accepted.
module pulse_width_frame_decoder_core
    import pwfd_pkg::*;
#(
    parameter int UNIT_SLOTS = UNIT_SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] edge_time_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] status_word,
    output logic [3:0]  raw_presence,
    output logic [3:0]  stable_presence,
    output logic [31:0] frame_count
);

    localparam int AW = $clog2(UNIT_SLOTS);
    localparam int CW = $clog2(UNIT_SLOTS + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_SCORE  = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [15:0]       thr_reg, thr_next;
    logic [15:0]       prev_reg, prev_next;
    logic              gap_reg, gap_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic              ok_reg, ok_next;
    logic [3:0]        score_reg [4];
    logic [3:0]        score_next [4];
    logic [3:0]        stable_reg, stable_next;
    logic [31:0]       fcount_reg, fcount_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers, no reset needed.
    logic [15:0]       interval_reg, interval_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [14:0]       word_reg, word_next;
    logic [UNIT_W-1:0] first_reg, first_next;
    logic [15:0]       status_reg, status_next;
    logic [3:0]        raw_reg, raw_next;

    // Unit store.
    logic [UNIT_W-1:0] mem [UNIT_SLOTS];
    logic [UNIT_W-1:0] rd_data_reg;
    logic              rd_en;
    logic              wr_en;
    logic [UNIT_W-1:0] unit_val;

    logic              out_free;
    logic              has_room;
    logic [ROUND_W-1:0] rounded;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign status_word     = status_reg;
    assign raw_presence    = raw_reg;
    assign stable_presence = stable_reg;
    assign frame_count     = fcount_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign has_room = (count_reg < CW'(UNIT_SLOTS));
    assign rounded  = ROUND_W'(interval_reg) + ROUND_W'(UNIT_HALF);
    // The reciprocal is exact for every 17-bit rounded interval, and a 16-bit
    // interval never rounds past 64 units, so no saturation is reachable.
    assign unit_val = prod_reg[RECIP_SHIFT +: UNIT_W];

    assign rd_en = (state_reg == ST_DECODE) && (rd_ptr_reg <= AW'(DEC_LAST));
    assign wr_en = (state_reg == ST_WRITE) && has_room;

    always_comb
    begin
        logic [4:0] sum;
        logic [3:0] s;
        logic [3:0] pres;
        logic       pair_bit;
        logic       pair_ok;
        logic       ok_upd;

        state_next     = state_reg;
        thr_next       = cfg_we ? cfg_wdata : thr_reg;
        prev_next      = prev_reg;
        gap_next       = gap_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        ok_next        = ok_reg;
        stable_next    = stable_reg;
        fcount_next    = fcount_reg;
        out_valid_next = out_valid_reg && !out_ready;
        interval_next  = interval_reg;
        prod_next      = prod_reg;
        word_next      = word_reg;
        first_next     = first_reg;
        status_next    = status_reg;
        raw_next       = raw_reg;
        for (int i = 0; i < 4; i++)
        begin
            score_next[i] = score_reg[i];
        end
        sum      = '0;
        s        = '0;
        pres     = presence_of(word_reg);
        pair_bit = (first_reg == SYM_ONE) && (rd_data_reg == SYM_TWO);
        pair_ok  = pair_bit || ((first_reg == SYM_TWO) && (rd_data_reg == SYM_ONE));
        ok_upd   = ok_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    interval_next = edge_time_us - prev_reg;
                    gap_next      = (edge_time_us - prev_reg) > thr_reg;
                    prev_next     = edge_time_us;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(rounded) * PROD_W'(UNIT_RECIP);
                if (gap_reg && (count_reg >= CW'(MIN_FRAME_UNITS)))
                begin
                    rd_ptr_next = AW'(1);
                    ok_next     = 1'b1;
                    state_next  = ST_DECODE;
                end
                else
                begin
                    if (gap_reg)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_DECODE:
            begin
                if (rd_en)
                begin
                    rd_ptr_next    = rd_ptr_reg + AW'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_ptr_reg;
                end
                if (chk_valid_reg)
                begin
                    // Header checks on entries 1 to 3, pairs from entry 5 on;
                    // entry 4 carries no information.
                    if (chk_idx_reg == AW'(1))
                    begin
                        ok_upd = ok_reg && (rd_data_reg >= HDR1_LO) && (rd_data_reg <= HDR1_HI);
                    end
                    else if ((chk_idx_reg == AW'(2)) || (chk_idx_reg == AW'(3)))
                    begin
                        ok_upd = ok_reg && (rd_data_reg >= HDR_LO) && (rd_data_reg <= HDR_HI);
                    end
                    else if (chk_idx_reg >= AW'(PAIR_FIRST))
                    begin
                        if (chk_idx_reg[0])
                        begin
                            first_next = rd_data_reg;
                        end
                        else
                        begin
                            ok_upd    = ok_reg && pair_ok;
                            word_next = {pair_bit, word_reg[14:1]};
                        end
                    end
                    ok_next = ok_upd;
                    if (chk_idx_reg == AW'(DEC_LAST))
                    begin
                        if (ok_upd)
                        begin
                            state_next = ST_SCORE;
                        end
                        else
                        begin
                            count_next = '0;
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_SCORE:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (pres[i])
                        begin
                            sum = {1'b0, score_reg[i]} + {1'b0, SCORE_UP};
                            s   = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[3:0];
                        end
                        else
                        begin
                            s = (score_reg[i] != 4'd0) ? score_reg[i] - 4'd1 : score_reg[i];
                        end
                        score_next[i] = s;
                        if (s >= STABLE_ON)
                        begin
                            stable_next[i] = 1'b1;
                        end
                        else if (s == 4'd0)
                        begin
                            stable_next[i] = 1'b0;
                        end
                    end
                    fcount_next    = fcount_reg + 32'd1;
                    status_next    = STATUS_VALID | {1'b0, word_reg};
                    raw_next       = pres;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    state_next     = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (has_room)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= GAP_RESET;
            prev_reg      <= '0;
            gap_reg       <= 1'b0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            ok_reg        <= 1'b0;
            stable_reg    <= '0;
            fcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                score_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            prev_reg      <= prev_next;
            gap_reg       <= gap_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            ok_reg        <= ok_next;
            stable_reg    <= stable_next;
            fcount_reg    <= fcount_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                score_reg[i] <= score_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        interval_reg <= interval_next;
        prod_reg     <= prod_next;
        word_reg     <= word_next;
        first_reg    <= first_next;
        status_reg   <= status_next;
        raw_reg      <= raw_next;
    end

    // Unit store memory: one write port, one registered read port. Reads and
    // writes happen in different sequencer states, so they never overlap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= unit_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// File: sv/pwfd_checker.sv
// Port-level checker for the pulse width frame decoder and its bind statement.
module pwfd_checker
    import pwfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] status_word,
    input logic [3:0]  raw_presence,
    input logic [31:0] frame_count
);

    // A result waiting at the output holds its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status_word) && $stable(frame_count))
        else $error("output word changed while stalled");

    // Every result carries the valid flag.
    a_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_word[15])
        else $error("status word without valid flag");

    // Raw presence follows from the decoded bit fields.
    a_presence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (raw_presence == presence_of(status_word[14:0])))
        else $error("raw presence does not match status word");

    // A result that follows a taken one at once belongs to the next frame.
    a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid || (frame_count == $past(frame_count) + 32'd1))
        else $error("result after a taken result does not advance the frame count");

    // An accepted edge drops in_ready in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind pulse_width_frame_decoder_core pwfd_checker u_pwfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status_word (status_word),
    .raw_presence(raw_presence),
    .frame_count (frame_count)
);

// File: tb/pwfd_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the pulse width frame decoder testbench: frame predictor and result checks.
package pwfd_tb_pkg;

    localparam int          STORE_DEPTH     = 48;
    localparam int unsigned EDGE_UNIT_US    = 1021;
    localparam int unsigned FRAME_MIN_UNITS = 35;
    localparam int          PAIR_BASE       = 5;
    localparam int unsigned SCORE_CAP       = 10;
    localparam int unsigned SCORE_SET       = 4;
    localparam logic [15:0] DEFAULT_GAP_US  = 16'd10000;

    typedef struct packed {
        logic [15:0] status_word;
        logic [3:0]  raw_presence;
        logic [3:0]  stable_presence;
        logic [31:0] frame_count;
    } frame_result_t;

    class frame_scoreboard;
        logic [15:0]   gap_us;
        logic [15:0]   last_edge;
        logic [7:0]    units [STORE_DEPTH];
        int unsigned   unit_fill;
        int unsigned   score [4];
        logic [3:0]    stable_mask;
        logic [31:0]   good_frames;
        frame_result_t expected_frames [$];
        int unsigned   error_count;
        int unsigned   results_checked;

        function new();
            gap_us          = DEFAULT_GAP_US;
            last_edge       = '0;
            unit_fill       = 0;
            foreach (score[i]) score[i] = 0;
            stable_mask     = '0;
            good_frames     = '0;
            error_count     = 0;
            results_checked = 0;
        endfunction

        function void set_gap(input logic [15:0] value);
            gap_us = value;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        // Round half up to whole units; a 16-bit interval never reaches the 255 ceiling,
        // but the clamp is kept so the rule reads as specified.
        function logic [7:0] round_units(input logic [15:0] interval);
            int unsigned u;
            u = (int'(interval) + EDGE_UNIT_US / 2) / EDGE_UNIT_US;
            if (u > 255) u = 255;
            return u[7:0];
        endfunction

        function bit decode_frame(output logic [14:0] word);
            logic [7:0] a;
            logic [7:0] c;
            word = '0;
            if (unit_fill < FRAME_MIN_UNITS) return 1'b0;
            if (units[1] < 3 || units[1] > 5) return 1'b0;
            if (units[2] < 2 || units[2] > 4) return 1'b0;
            if (units[3] < 2 || units[3] > 4) return 1'b0;
            for (int b = 0; b < 15; b++)
            begin
                a = units[PAIR_BASE + 2 * b];
                c = units[PAIR_BASE + 2 * b + 1];
                if (a == 8'd1 && c == 8'd2) word[b] = 1'b1;
                else if (!(a == 8'd2 && c == 8'd1)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void update_scores(input logic [3:0] present);
            for (int i = 0; i < 4; i++)
            begin
                if (present[i]) score[i] = (score[i] + 2 > SCORE_CAP) ? SCORE_CAP : score[i] + 2;
                else if (score[i] > 0) score[i] = score[i] - 1;
                if (score[i] >= SCORE_SET) stable_mask[i] = 1'b1;
                else if (score[i] == 0) stable_mask[i] = 1'b0;
            end
        endfunction

        // Called for every accepted edge word; queues the result it causes, if any.
        function void note_edge(input logic [15:0] edge_stamp);
            logic [15:0]   interval;
            logic [14:0]   word;
            logic [3:0]    present;
            frame_result_t r;
            interval  = edge_stamp - last_edge;
            last_edge = edge_stamp;
            if (interval > gap_us)
            begin
                if (decode_frame(word))
                begin
                    present = {|word[14:13], |word[12:10], |word[9:7], |word[6:4]};
                    update_scores(present);
                    good_frames++;
                    r.status_word     = {1'b1, word};
                    r.raw_presence    = present;
                    r.stable_presence = stable_mask;
                    r.frame_count     = good_frames;
                    expected_frames.push_back(r);
                end
                unit_fill = 0;
            end
            if (unit_fill < STORE_DEPTH)
            begin
                units[unit_fill] = round_units(interval);
                unit_fill++;
            end
        endfunction

        function void check_result(input logic [15:0] status, input logic [3:0] raw,
                                   input logic [3:0] stable, input logic [31:0] count);
            frame_result_t exp_r;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: result word with no frame pending: status_word %h count %0d",
                         $time, status, count);
                error_count++;
                return;
            end
            exp_r = expected_frames.pop_front();
            results_checked++;
            if (status !== exp_r.status_word)
            begin
                $display("%0t: status_word expected %h actual %h", $time, exp_r.status_word,
                         status);
                error_count++;
            end
            if (raw !== exp_r.raw_presence)
            begin
                $display("%0t: raw_presence expected %b actual %b", $time, exp_r.raw_presence,
                         raw);
                error_count++;
            end
            if (stable !== exp_r.stable_presence)
            begin
                $display("%0t: stable_presence expected %b actual %b", $time,
                         exp_r.stable_presence, stable);
                error_count++;
            end
            if (count !== exp_r.frame_count)
            begin
                $display("%0t: frame_count expected %0d actual %0d", $time, exp_r.frame_count,
                         count);
                error_count++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb_pulse_width_frame_decoder_core.sv
`timescale 1ns / 100ps
// Testbench top for the pulse width frame decoder core: stimulus, handshakes and final verdict.
module tb_pulse_width_frame_decoder_core;
    import pwfd_tb_pkg::*;

    // Cycles with no word moving on either channel before the run is declared hung.
    // The longest legal quiet stretch is a settle pause plus one decode sweep.
    localparam int IDLE_LIMIT    = 4000;
    // Quiet cycles allowed after the last expected result, since an edge that ends
    // a rejected frame still occupies the decode sweep without producing anything.
    localparam int SETTLE_CYCLES = 60;

    // Ways a generated frame may be spoiled on purpose.
    typedef enum int unsigned {
        FRAME_GOOD,
        FRAME_BAD_HDR1,
        FRAME_BAD_HDR2,
        FRAME_BAD_HDR3,
        FRAME_BAD_PAIR,
        FRAME_SHORT,
        FRAME_OVERFULL
    } frame_flaw_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [15:0] cfg_wdata       = '0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [15:0] edge_time_us    = '0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [15:0] status_word;
    logic [3:0]  raw_presence;
    logic [3:0]  stable_presence;
    logic [31:0] frame_count;

    frame_scoreboard sb;

    bit          idle_en         = 1'b1;
    int unsigned rx_hold         = 0;
    int unsigned idle_cycles     = 0;
    int unsigned edges_sent      = 0;
    int unsigned settings_used   = 0;
    logic [15:0] now_us          = '0;
    logic [15:0] gap_setting     = DEFAULT_GAP_US;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pulse_width_frame_decoder_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .edge_time_us    (edge_time_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status_word     (status_word),
        .raw_presence    (raw_presence),
        .stable_presence (stable_presence),
        .frame_count     (frame_count)
    );

    // Result side: out_ready drops at random while idling is enabled, and stays
    // high for the whole closing stretch of the run.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready = 1'b0;
            rx_hold   = rx_hold - 1;
        end
        else if (idle_en && $urandom_range(5, 0) == 0)
        begin
            out_ready = 1'b0;
            rx_hold   = $urandom_range(2, 0);
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    // Both channels are observed at the rising edge, where the values seen are the
    // ones the block itself sampled. Edge words feed the predictor, result words
    // are checked against it, and the quiet-cycle count drives the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready) sb.note_edge(edge_time_us);
            if (out_valid && out_ready)
                sb.check_result(status_word, raw_presence, stable_presence, frame_count);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no word moved for %0d cycles, %0d results still pending", $time,
                 IDLE_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one edge word and holds it until accepted. Every call starts and ends at a
    // falling edge with in_valid low, so the payload never changes under a pending word.
    task automatic send_edge(input logic [15:0] stamp);
        if (idle_en && $urandom_range(4, 0) == 0) repeat ($urandom_range(3, 1)) @(negedge clk);
        in_valid     = 1'b1;
        edge_time_us = stamp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid   = 1'b0;
        edges_sent = edges_sent + 1;
    endtask

    task automatic step_by(input int unsigned dt);
        now_us = now_us + dt[15:0];
        send_edge(now_us);
    endtask

    // An interval picked anywhere inside the band that rounds to u units.
    function automatic int unsigned span_for(input int unsigned u);
        int unsigned lo;
        int unsigned hi;
        lo = (u == 0) ? 0 : u * EDGE_UNIT_US - EDGE_UNIT_US / 2;
        hi = u * EDGE_UNIT_US + EDGE_UNIT_US / 2;
        if (hi > 65535) hi = 65535;
        return $urandom_range(hi, lo);
    endfunction

    // An interval above the threshold closes the frame in progress. With the threshold
    // at its top value nothing can exceed it, so a plain header-sized unit goes instead.
    task automatic send_gap();
        if (gap_setting == 16'hFFFF) step_by(span_for(3));
        else step_by($urandom_range(65535, int'(gap_setting) + 1));
    endtask

    task automatic noise_burst(input int unsigned count);
        repeat (count)
        begin
            now_us = 16'($urandom_range(65535, 0));
            send_edge(now_us);
        end
    endtask

    // One frame: the gap edge that becomes entry 0, three header units, an ignored unit,
    // fifteen unit pairs and a few trailing units. The frame is decoded when the next
    // gap arrives, which is the start of the following frame or the closing gap.
    task automatic send_frame(input logic [14:0] word, input frame_flaw_t flaw);
        int unsigned seq [$];
        int unsigned hdr [3];
        int unsigned bad_bit;
        int unsigned extra;
        int unsigned a;
        int unsigned c;
        hdr[0]  = $urandom_range(5, 3);
        hdr[1]  = $urandom_range(4, 2);
        hdr[2]  = $urandom_range(4, 2);
        bad_bit = $urandom_range(14, 0);
        case (flaw)
            FRAME_BAD_HDR1: hdr[0] = $urandom_range(1, 0) ? $urandom_range(2, 0)
                                                          : $urandom_range(9, 6);
            FRAME_BAD_HDR2: hdr[1] = $urandom_range(1, 0) ? $urandom_range(1, 0)
                                                          : $urandom_range(8, 5);
            FRAME_BAD_HDR3: hdr[2] = $urandom_range(1, 0) ? $urandom_range(1, 0)
                                                          : $urandom_range(8, 5);
            default: ;
        endcase
        // Enough trailing units on an overfull frame to run past the end of the store.
        extra = (flaw == FRAME_OVERFULL) ? $urandom_range(20, 14) : $urandom_range(4, 0);
        seq = {hdr[0], hdr[1], hdr[2], $urandom_range(5, 0)};
        for (int b = 0; b < 15; b++)
        begin
            if (flaw == FRAME_BAD_PAIR && b == bad_bit)
            begin
                a = $urandom_range(3, 0);
                c = $urandom_range(3, 0);
                if ((a == 1 && c == 2) || (a == 2 && c == 1)) c = a;
                seq.push_back(a);
                seq.push_back(c);
            end
            else if (word[b])
            begin
                seq.push_back(1);
                seq.push_back(2);
            end
            else
            begin
                seq.push_back(2);
                seq.push_back(1);
            end
        end
        repeat (extra) seq.push_back($urandom_range(5, 0));
        // A short frame keeps fewer than 35 units counting the gap entry.
        if (flaw == FRAME_SHORT) seq = seq[0:$urandom_range(33, 4) - 1];
        send_gap();
        foreach (seq[i]) step_by(span_for(seq[i]));
    endtask

    // Mostly well-formed frames with random words, some spoiled frames and some noise.
    // The bias decides how often a slot's bit field is forced empty, so presence scores
    // both climb to their cap and decay to zero over a phase.
    task automatic run_frames(input int unsigned edge_budget);
        int unsigned bias;
        int unsigned stop;
        int unsigned pick;
        logic [14:0] word;
        frame_flaw_t flaw;
        bias = $urandom_range(3, 0);
        stop = edges_sent + edge_budget;
        while (edges_sent < stop)
        begin
            word = 15'($urandom_range(32767, 0));
            if ($urandom_range(3, 0) < bias) word[6:4]   = '0;
            if ($urandom_range(3, 0) < bias) word[9:7]   = '0;
            if ($urandom_range(3, 0) < bias) word[12:10] = '0;
            if ($urandom_range(3, 0) < bias) word[14:13] = '0;
            if ($urandom_range(19, 0) == 0) word = $urandom_range(1, 0) ? 15'h7FFF : 15'h0000;
            pick = $urandom_range(99, 0);
            if (pick < 66)      flaw = FRAME_GOOD;
            else if (pick < 70) flaw = FRAME_BAD_HDR1;
            else if (pick < 74) flaw = FRAME_BAD_HDR2;
            else if (pick < 78) flaw = FRAME_BAD_HDR3;
            else if (pick < 84) flaw = FRAME_BAD_PAIR;
            else if (pick < 89) flaw = FRAME_SHORT;
            else                flaw = FRAME_OVERFULL;
            if (pick >= 95) noise_burst($urandom_range(5, 1));
            else send_frame(word, flaw);
            if ($urandom_range(9, 0) == 0) bias = $urandom_range(3, 0);
        end
        send_gap();
    endtask

    // Waits for every predicted result word, then lets the decode sweep of a possibly
    // rejected frame finish before anything else happens.
    task automatic settle();
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gap(input logic [15:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we        = 1'b0;
        gap_setting   = value;
        settings_used = settings_used + 1;
        sb.set_gap(value);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_gap(DEFAULT_GAP_US);

        // Directed edges: the first edge is measured from time zero, then the rounding
        // boundaries around half a unit and one and a half units, a long interval that
        // ends a too-short frame, wrap-around of the counter and a zero interval.
        send_edge(16'd0);
        send_edge(16'd510);
        send_edge(16'd1021);
        send_edge(16'd2552);
        send_edge(16'd4084);
        send_edge(16'hFFFF);
        send_edge(16'h0000);
        send_edge(16'h0000);
        send_edge(16'h5555);
        send_edge(16'hAAAA);
        send_edge(16'h7FFF);
        send_edge(16'h8000);
        send_edge(16'hFFFF);
        now_us = 16'hFFFF;

        run_frames(260);

        // Threshold at zero: nearly every edge ends a frame, so nothing can decode.
        write_gap(16'h0000);
        noise_burst(60);

        // Threshold at its top: no interval can exceed it and the store overfills.
        write_gap(16'hFFFF);
        noise_burst(30);
        run_frames(80);

        // Just below the top: only a full-scale interval closes a frame.
        write_gap(16'hFFFE);
        run_frames(250);

        // A low threshold just above the longest well-formed in-frame interval, with a pause in the
        // middle of the phase until every pending result word has arrived.
        write_gap(16'($urandom_range(9000, 5700)));
        run_frames(200);
        settle();
        run_frames(200);

        write_gap(16'($urandom_range(65000, 20000)));
        run_frames(250);

        // Closing stretch without any idling on either side.
        idle_en = 1'b0;
        write_gap(16'($urandom_range(65534, 5700)));
        run_frames(250);

        settle();
        $display("Sent %0d edge words across %0d threshold settings; %0d decoded frames checked.",
                 edges_sent, settings_used, sb.results_checked);
        if (sb.error_count == 0 && sb.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
